### hw/rtl/tlr_pkg.sv
// Shared constants, types and helpers of the thick line rasterizer.
`default_nettype none

package tlr_pkg;

    // Coordinate and field widths
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 14;
    localparam int BRUSH_W    = 3;
    localparam int COLOR_W    = 32;
    localparam int ALPHA_W    = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Largest brush half side; brush counters run 0 .. 2*MAX_BRUSH-1
    localparam int MAX_BRUSH = 4;
    localparam int CNT_W     = (2 * MAX_BRUSH > 2) ? $clog2(2 * MAX_BRUSH) : 1;

    // Divider sizing
    localparam int PROD_W    = 2 * COORD_W;
    localparam int DIV_CNT_W = $clog2(COORD_W + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BRUSH_W-1:0] BRUSH_RESET = BRUSH_W'(2);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_START    = 3'd0,
        REG_Y_START    = 3'd1,
        REG_X_END      = 3'd2,
        REG_Y_END      = 3'd3,
        REG_BRUSH_HALF = 3'd4,
        REG_PEN_COLOR  = 3'd5,
        REG_PEN_ALPHA  = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [BRUSH_W-1:0] brush_half;
        logic [COLOR_W-1:0] pen_color;
        logic [ALPHA_W-1:0] pen_alpha;
    } cfg_t;

    // Classified step index, as held by the front
    typedef struct packed {
        logic [COORD_W-1:0] idx;
        logic               item_valid;
        logic               major_x;
        logic [COORD_W-1:0] maj_coord;
        logic [COORD_W-1:0] min_start;
        logic [COORD_W-1:0] min_delta;
        logic [COORD_W-1:0] len;
    } front_desc_t;

    // Brush center handed to the back
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               pix_valid;
    } queue_entry_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    function automatic logic [BRUSH_W-1:0] clamp_brush(input logic [BRUSH_W-1:0] half);
        logic [BRUSH_W-1:0] t;
        t = half;
        if (t == '0) begin
            t = BRUSH_W'(1);
        end
        if (t > BRUSH_W'(MAX_BRUSH)) begin
            t = BRUSH_W'(MAX_BRUSH);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tlr_front.sv
// Front stage: accept a step index and classify it against the line registers.
`default_nettype none

module tlr_front import tlr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [COORD_W-1:0] s_step_index,
    output logic                    f_valid,
    input  wire logic               f_ready,
    output front_desc_t             f_desc
);

    logic        f_valid_reg, f_valid_next;
    front_desc_t desc_reg, desc_next;

    logic [COORD_W-1:0] dx, dy;
    logic               major_x;
    logic               accept;

    assign s_ready = !f_valid_reg || f_ready;
    assign accept  = s_valid && s_ready;

    // An axis whose end lies before its start has zero delta
    always_comb begin
        dx      = (cfg.x_end >= cfg.x_start) ? (cfg.x_end - cfg.x_start) : '0;
        dy      = (cfg.y_end >= cfg.y_start) ? (cfg.y_end - cfg.y_start) : '0;
        major_x = (dx > dy);

        desc_next.idx        = s_step_index;
        desc_next.major_x    = major_x;
        desc_next.len        = major_x ? dx : dy;
        desc_next.item_valid = (s_step_index < desc_next.len);
        desc_next.maj_coord  = (major_x ? cfg.x_start : cfg.y_start) + s_step_index;
        desc_next.min_start  = major_x ? cfg.y_start : cfg.x_start;
        desc_next.min_delta  = major_x ? dy : dx;
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (f_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_desc  = desc_reg;

endmodule

`default_nettype wire

### hw/rtl/tlr_div.sv
// Minor-axis unit: multiply once, then restoring division one quotient bit a cycle.
`default_nettype none

module tlr_div import tlr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire front_desc_t in_desc,
    output logic             out_valid,
    input  wire logic        out_ready,
    output queue_entry_t     out_entry
);

    div_state_t state_reg, state_next;

    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   dq_reg, dq_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0]   len_reg;
    logic [COORD_W-1:0]   maj_reg;
    logic [COORD_W-1:0]   min_start_reg;
    logic                 major_x_reg;
    logic                 valid_reg;

    logic [PROD_W-1:0]  prod;
    logic [COORD_W:0]   trial;
    logic               trial_ge;
    logic [COORD_W-1:0] minor;
    logic               accept;

    // Outputs of the state machine
    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                in_ready = 1'b1;
            end
            DIV_RUN: begin
                in_ready = 1'b0;
            end
            DIV_DONE: begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (accept) begin
                    state_next = in_desc.item_valid ? DIV_RUN : DIV_DONE;
                end
            end
            DIV_RUN: begin
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (accept) begin
                    state_next = in_desc.item_valid ? DIV_RUN : DIV_DONE;
                end else if (out_ready) begin
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // Quotient is known to fit COORD_W bits, so the high half of the
    // product starts as the partial remainder
    assign prod     = PROD_W'(in_desc.min_delta) * PROD_W'(in_desc.idx);
    assign trial    = {rem_reg, dq_reg[COORD_W-1]};
    assign trial_ge = (trial >= {1'b0, len_reg});

    always_comb begin
        rem_next = rem_reg;
        dq_next  = dq_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            rem_next = prod[PROD_W-1:COORD_W];
            dq_next  = prod[COORD_W-1:0];
            cnt_next = DIV_CNT_W'(COORD_W);
        end else if (state_reg == DIV_RUN) begin
            rem_next = trial_ge ? COORD_W'(trial - {1'b0, len_reg}) : trial[COORD_W-1:0];
            dq_next  = {dq_reg[COORD_W-2:0], trial_ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        cnt_reg <= cnt_next;
        if (accept) begin
            len_reg       <= in_desc.len;
            maj_reg       <= in_desc.maj_coord;
            min_start_reg <= in_desc.min_start;
            major_x_reg   <= in_desc.major_x;
            valid_reg     <= in_desc.item_valid;
        end
    end

    assign minor = min_start_reg + dq_reg;

    always_comb begin
        out_entry.cx        = major_x_reg ? maj_reg : minor;
        out_entry.cy        = major_x_reg ? minor : maj_reg;
        out_entry.pix_valid = valid_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/tlr_queue.sv
// Short queue of brush centers between the front and the back.
`default_nettype none

module tlr_queue import tlr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire queue_entry_t in_entry,
    output logic              out_valid,
    input  wire logic         out_ready,
    output queue_entry_t      out_entry
);

    queue_entry_t entry_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

    assign out_entry = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### hw/rtl/tlr_back.sv
// Back stage: sweep the square brush around each center, one pixel word a cycle while the output is not stalled.
`default_nettype none

module tlr_back import tlr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cfg_t         cfg,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire queue_entry_t q_entry,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [PIX_W-1:0]  m_pixel_x,
    output logic [PIX_W-1:0]  m_pixel_y,
    output logic [COLOR_W-1:0] m_out_color,
    output logic [ALPHA_W-1:0] m_out_alpha,
    output logic              m_pixel_valid,
    output logic              m_last_of_run
);

    logic         cur_valid_reg, cur_valid_next;
    queue_entry_t cur_reg;
    logic [CNT_W-1:0] cnt_x_reg, cnt_x_next;
    logic [CNT_W-1:0] cnt_y_reg, cnt_y_next;

    logic               m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]   px_reg, py_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               pvalid_reg, last_reg;

    logic [BRUSH_W-1:0] side;
    logic [BRUSH_W:0]   side2;
    logic [CNT_W-1:0]   last_cnt;
    logic               adv, last_pix, take;
    logic [PIX_W-1:0]   px, py;

    assign side     = clamp_brush(cfg.brush_half);
    assign side2    = {side, 1'b0};
    assign last_cnt = CNT_W'(side2 - 1'b1);

    assign adv      = cur_valid_reg && (!m_valid_reg || m_ready);
    assign last_pix = !cur_reg.pix_valid || ((cnt_x_reg == last_cnt) && (cnt_y_reg == last_cnt));
    assign q_ready  = !cur_valid_reg || (adv && last_pix);
    assign take     = q_valid && q_ready;

    // Offset runs from -side to side-1: center + count - side
    assign px = PIX_W'(cur_reg.cx) + PIX_W'(cnt_x_reg) - PIX_W'(side);
    assign py = PIX_W'(cur_reg.cy) + PIX_W'(cnt_y_reg) - PIX_W'(side);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cnt_x_next     = cnt_x_reg;
        cnt_y_next     = cnt_y_reg;
        if (take) begin
            cur_valid_next = 1'b1;
            cnt_x_next     = '0;
            cnt_y_next     = '0;
        end else if (adv) begin
            if (last_pix) begin
                cur_valid_next = 1'b0;
            end else if (cnt_y_reg == last_cnt) begin
                cnt_y_next = '0;
                cnt_x_next = cnt_x_reg + CNT_W'(1);
            end else begin
                cnt_y_next = cnt_y_reg + CNT_W'(1);
            end
        end

        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_x_reg <= cnt_x_next;
        cnt_y_reg <= cnt_y_next;
        if (take) begin
            cur_reg <= q_entry;
        end
        if (adv) begin
            if (cur_reg.pix_valid) begin
                px_reg    <= px;
                py_reg    <= py;
                color_reg <= cfg.pen_color;
                alpha_reg <= cfg.pen_alpha;
            end else begin
                px_reg    <= '0;
                py_reg    <= '0;
                color_reg <= '0;
                alpha_reg <= '0;
            end
            pvalid_reg <= cur_reg.pix_valid;
            last_reg   <= last_pix;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_out_color   = color_reg;
    assign m_out_alpha   = alpha_reg;
    assign m_pixel_valid = pvalid_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire

### hw/rtl/thick_line_rasterizer_unit.sv
// The back emits one pixel word a cycle while the output is not stalled. The minor-axis
//   divider loads the product once and, for an index on the line, gives one quotient bit
//   per cycle; it takes a new step index only when idle or handing its result on.
// Reset (aresetn low, synchronous): empties front, divider, queue and back; line registers
//   return to zero, brush half to 2. No clearing pass is needed.
`default_nettype none

module thick_line_rasterizer_unit import tlr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Step index words in
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_W-1:0]    s_step_index,

    // Pixel words out
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PIX_W-1:0]           m_pixel_x,
    output logic [PIX_W-1:0]           m_pixel_y,
    output logic [COLOR_W-1:0]         m_out_color,
    output logic [ALPHA_W-1:0]         m_out_alpha,
    output logic                       m_pixel_valid,
    output logic                       m_last_of_run
);

    // ------------------------------------------------------------------
    // Line registers. They must be written only while the pipe is empty, so every
    // stage may read them directly; the block itself does not enforce this.
    // ------------------------------------------------------------------
    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_X_START:    cfg_next.x_start    = cfg_wdata[COORD_W-1:0];
                REG_Y_START:    cfg_next.y_start    = cfg_wdata[COORD_W-1:0];
                REG_X_END:      cfg_next.x_end      = cfg_wdata[COORD_W-1:0];
                REG_Y_END:      cfg_next.y_end      = cfg_wdata[COORD_W-1:0];
                REG_BRUSH_HALF: cfg_next.brush_half = cfg_wdata[BRUSH_W-1:0];
                REG_PEN_COLOR:  cfg_next.pen_color  = cfg_wdata[COLOR_W-1:0];
                REG_PEN_ALPHA:  cfg_next.pen_alpha  = cfg_wdata[ALPHA_W-1:0];
                default: begin
                    // drop writes to unused indexes
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_start    <= '0;
            cfg_reg.y_start    <= '0;
            cfg_reg.x_end      <= '0;
            cfg_reg.y_end      <= '0;
            cfg_reg.brush_half <= BRUSH_RESET;
            cfg_reg.pen_color  <= '0;
            cfg_reg.pen_alpha  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front: accept and classify (delta, major axis, in-range check)
    // ------------------------------------------------------------------
    logic        f_valid, f_ready;
    front_desc_t f_desc;

    tlr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_step_index (s_step_index),
        .f_valid      (f_valid),
        .f_ready      (f_ready),
        .f_desc       (f_desc)
    );

    // ------------------------------------------------------------------
    // Divider: minor coordinate = start + delta*index / length
    // ------------------------------------------------------------------
    logic         d_valid, d_ready;
    queue_entry_t d_entry;

    tlr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_desc   (f_desc),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_entry (d_entry)
    );

    // ------------------------------------------------------------------
    // Queue: hold brush centers so the back can stall on its own
    // ------------------------------------------------------------------
    logic         q_valid, q_ready;
    queue_entry_t q_entry;

    tlr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_entry  (d_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    // ------------------------------------------------------------------
    // Back: sweep the brush, x offset outer, y offset inner
    // ------------------------------------------------------------------
    tlr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_out_color   (m_out_color),
        .m_out_alpha   (m_out_alpha),
        .m_pixel_valid (m_pixel_valid),
        .m_last_of_run (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic signed [PIX_W-1:0] chk_x, chk_y;
    assign chk_x = m_pixel_x;
    assign chk_y = m_pixel_y;

    // An out-of-range index gives a single zeroed word that closes its run
    a_invalid_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pixel_valid) |-> (m_last_of_run && (m_pixel_x == '0)
                                         && (m_pixel_y == '0)))
        else $error("invalid word not zeroed or not last");

    // A brush run leaves no gap: after a non-final word is taken, the next follows
    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("gap inside a brush run");

    // Brush pixels stay within the brush reach around the coordinate range
    a_pixel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pixel_valid) |->
            ((chk_x >= -PIX_W'(MAX_BRUSH)) && (chk_x < PIX_W'((1 << COORD_W) + MAX_BRUSH))
             && (chk_y >= -PIX_W'(MAX_BRUSH))
             && (chk_y < PIX_W'((1 << COORD_W) + MAX_BRUSH))))
        else $error("pixel coordinate out of reach");

endmodule

`default_nettype wire

### test/thick_line_rasterizer_unit_tb.sv
// Self-checking testbench of the thick line rasterizer: brush pixel words checked against a local predictor.
`default_nettype none

module thick_line_rasterizer_unit_tb;
    import tlr_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 4;
    // No word in either direction for this many cycles ends the run
    localparam int IDLE_LIMIT      = 3000;
    // Quiet cycles after the last expected word, well above the block's latency
    localparam int SETTLE_CYCLES   = 32;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int COORD_MAX       = (1 << COORD_W) - 1;

    // One expected pixel word
    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
        logic               valid;
        logic               last_flag;
    } pixel_word_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [COORD_W-1:0]    s_step_index  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [PIX_W-1:0]      m_pixel_x;
    logic [PIX_W-1:0]      m_pixel_y;
    logic [COLOR_W-1:0]    m_out_color;
    logic [ALPHA_W-1:0]    m_out_alpha;
    logic                  m_pixel_valid;
    logic                  m_last_of_run;

    // Predictor's copy of the line registers
    cfg_t        line_cfg;
    // Pixel words still owed by the block, oldest first
    pixel_word_t pixel_q[$];

    int error_count  = 0;
    int idle_cycles  = 0;
    // Idling knobs, flipped per phase by the tests
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    // Long receiver hold-off asked by a test; the receiver takes it over and counts it down
    int hold_off_req = 0;

    always #HALF_PERIOD aclk = ~aclk;

    thick_line_rasterizer_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_step_index  (s_step_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_out_color   (m_out_color),
        .m_out_alpha   (m_out_alpha),
        .m_pixel_valid (m_pixel_valid),
        .m_last_of_run (m_last_of_run)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // An axis whose end lies below its start does not move
    function automatic int unsigned axis_delta(input int unsigned from, input int unsigned to);
        return (to >= from) ? to - from : 0;
    endfunction

    // Queue every pixel word that one step index causes
    function automatic void predict_brush_pixels(input logic [COORD_W-1:0] idx);
        int unsigned xs, ys, dx, dy, len, cx, cy, i;
        int          t, ox, oy;
        pixel_word_t w;
        xs = line_cfg.x_start;
        ys = line_cfg.y_start;
        dx = axis_delta(xs, line_cfg.x_end);
        dy = axis_delta(ys, line_cfg.y_end);
        i  = idx;
        // Ties go to the row axis
        if (dx > dy) begin
            len = dx;
            cx  = xs + i;
            cy  = ys + (dy * i) / len;
        end else begin
            len = dy;
            cy  = ys + i;
            cx  = (len != 0) ? xs + (dx * i) / len : xs;
        end
        w = '0;
        // Off the end of the line: one empty word that closes the run
        if (i >= len) begin
            w.last_flag = 1'b1;
            pixel_q.push_back(w);
            return;
        end
        t = line_cfg.brush_half;
        if (t < 1) t = 1;
        if (t > MAX_BRUSH) t = MAX_BRUSH;
        w.color = line_cfg.pen_color;
        w.alpha = line_cfg.pen_alpha;
        w.valid = 1'b1;
        // x offset outer, y offset inner
        for (ox = -t; ox < t; ox++) begin
            for (oy = -t; oy < t; oy++) begin
                w.x         = PIX_W'(int'(cx) + ox);
                w.y         = PIX_W'(int'(cy) + oy);
                w.last_flag = (ox == t - 1) && (oy == t - 1);
                pixel_q.push_back(w);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Write one register at the next edge; the caller closes the burst
    task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        case (r)
            REG_X_START:    line_cfg.x_start    = v[COORD_W-1:0];
            REG_Y_START:    line_cfg.y_start    = v[COORD_W-1:0];
            REG_X_END:      line_cfg.x_end      = v[COORD_W-1:0];
            REG_Y_END:      line_cfg.y_end      = v[COORD_W-1:0];
            REG_BRUSH_HALF: line_cfg.brush_half = v[BRUSH_W-1:0];
            REG_PEN_COLOR:  line_cfg.pen_color  = v[COLOR_W-1:0];
            REG_PEN_ALPHA:  line_cfg.pen_alpha  = v[ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Load the whole line setup; upper data bits may carry junk
    task automatic write_line(input logic [CFG_DATA_W-1:0] xs, ys, xe, ye, bh, color, alpha);
        write_reg(REG_X_START, xs);
        write_reg(REG_Y_START, ys);
        write_reg(REG_X_END, xe);
        write_reg(REG_Y_END, ye);
        write_reg(REG_BRUSH_HALF, bh);
        write_reg(REG_PEN_COLOR, color);
        write_reg(REG_PEN_ALPHA, alpha);
        close_writes();
    endtask

    // Offer one step index, hold it until taken, then maybe drop valid for a while
    task automatic send_step(input logic [COORD_W-1:0] idx);
        int gap;
        s_valid      <= 1'b1;
        s_step_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_brush_pixels(idx);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every owed word has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    task automatic check_pixel_word();
        pixel_word_t exp_w;
        if (pixel_q.size() == 0) begin
            $error("unexpected pixel word: x %0d y %0d valid %0b last %0b",
                   $signed(m_pixel_x), $signed(m_pixel_y), m_pixel_valid, m_last_of_run);
            error_count++;
        end else begin
            exp_w = pixel_q.pop_front();
            check_field("pixel_x", $signed(exp_w.x), $signed(m_pixel_x));
            check_field("pixel_y", $signed(exp_w.y), $signed(m_pixel_y));
            check_field("out_color", exp_w.color, m_out_color);
            check_field("out_alpha", exp_w.alpha, m_out_alpha);
            check_field("pixel_valid", exp_w.valid, m_pixel_valid);
            check_field("last_of_run", exp_w.last_flag, m_last_of_run);
        end
    endtask

    // Check each word taken at this edge, then pick ready for the next one
    int rx_hold = 0;
    int rx_wait = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_pixel_word();
            if (hold_off_req > 0) begin
                rx_hold      = hold_off_req;
                hold_off_req = 0;
            end
            if (rx_hold > 0) begin
                // Long hold-off: let the block fill up and stall its input
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
                rx_wait = rx_stalls_on ? pick_gap() : 0;
            end
        end
    end

    // Watchdog: a run with no word moving for too long is hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Corners often, anything else otherwise
    function automatic int unsigned pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return COORD_MAX;
        return $urandom_range(0, COORD_MAX);
    endfunction

    // Mostly an end at or past the start, short lines favored; sometimes behind it
    function automatic int unsigned pick_end(input int unsigned start);
        int          r;
        int unsigned room;
        r    = $urandom_range(0, 9);
        room = COORD_MAX - start;
        if (r < 2) return $urandom_range(0, start);
        if (r < 6) return start + $urandom_range(0, (room < 48) ? room : 48);
        return start + $urandom_range(0, room);
    endfunction

    // Mostly indices on the line, some just past its end, some anywhere
    function automatic logic [COORD_W-1:0] pick_index();
        int          r;
        int unsigned dx, dy, len, k;
        dx  = axis_delta(line_cfg.x_start, line_cfg.x_end);
        dy  = axis_delta(line_cfg.y_start, line_cfg.y_end);
        len = (dx > dy) ? dx : dy;
        r   = $urandom_range(0, 99);
        if (r < 80 && len > 0) return COORD_W'($urandom_range(0, len - 1));
        if (r < 90) begin
            k = len + $urandom_range(0, 3);
            return COORD_W'((k > COORD_MAX) ? COORD_MAX : k);
        end
        return COORD_W'($urandom_range(0, COORD_MAX));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves a zero-length line; the brush half must come up as 2
    task automatic test_reset_defaults();
        send_step(COORD_W'(0));
        send_step(COORD_W'(COORD_MAX));
        wait_drained();
        write_reg(REG_Y_END, 5);
        close_writes();
        send_step(COORD_W'(0));
        send_step(COORD_W'(4));
        send_step(COORD_W'(5));
        wait_drained();
    endtask

    // Field extremes, both major axes, ties, reversed ends, brush clamping, wide writes
    task automatic test_directed_lines();
        // Full-width column-major line, smallest brush, all-ones pen
        write_line(0, 0, COORD_MAX, 10, 1, 32'hFFFF_FFFF, 8'hFF);
        send_step(COORD_W'(0));
        send_step(COORD_W'(COORD_MAX - 1));
        send_step(COORD_W'(COORD_MAX));
        send_step(COORD_W'(2048));
        wait_drained();
        // Equal deltas go row-major; largest brush, all-zero pen
        write_line(100, 200, 300, 400, 4, 32'h0, 8'h0);
        send_step(COORD_W'(0));
        send_step(COORD_W'(199));
        send_step(COORD_W'(200));
        wait_drained();
        // Column end behind its start counts as no column motion; brush zero raised to one
        write_line(10, 0, 5, 50, 0, 32'h5A5A_A5A5, 8'h80);
        send_step(COORD_W'(0));
        send_step(COORD_W'(49));
        send_step(COORD_W'(50));
        wait_drained();
        // Both ends behind: zero-length line
        write_line(COORD_MAX, COORD_MAX, 0, 0, 3, 32'h1357_9BDF, 8'h01);
        send_step(COORD_W'(0));
        send_step(COORD_W'(COORD_MAX));
        wait_drained();
        // Junk above each register's width; brush 7 lowered to the maximum; pixels past 4095
        write_line(32'hFFFF_FFFD, 32'h0000_AFFA, 32'h1234_5FFD, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FF81);
        send_step(COORD_W'(4));
        send_step(COORD_W'(0));
        send_step(COORD_W'(5));
        wait_drained();
        // Brush 5 lowered too; origin line gives negative pixels
        write_line(0, 0, 3, 1, 5, 32'hAAAA_5555, 8'h55);
        send_step(COORD_W'(0));
        send_step(COORD_W'(1));
        send_step(COORD_W'(2));
        wait_drained();
    endtask

    // Hold the receiver off while indices keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        write_line(0, 0, 30, 20, 4, 32'hA5A5_5A5A, 8'h3C);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        hold_off_req = 400;
        for (n = 0; n < 16; n++) begin
            send_step(COORD_W'($urandom_range(0, 29)));
        end
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // Bursts separated by a full drain of the block
    task automatic test_sender_pause();
        int burst, n;
        write_line(40, 60, 52, 95, 2, $urandom(), $urandom());
        for (burst = 0; burst < 3; burst++) begin
            for (n = 0; n < 4; n++) begin
                send_step(pick_index());
            end
            wait_drained();
        end
    endtask

    // Random lines, each phase with its own idling mix
    task automatic test_random_lines();
        int          phase, n;
        int unsigned xs, ys;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            xs = pick_coord();
            ys = pick_coord();
            write_line(($urandom() & 32'hFFFF_F000) | xs,
                       ($urandom() & 32'hFFFF_F000) | ys,
                       ($urandom() & 32'hFFFF_F000) | pick_end(xs),
                       ($urandom() & 32'hFFFF_F000) | pick_end(ys),
                       ($urandom() & 32'hFFFF_FFF8) | $urandom_range(0, 7),
                       $urandom(), $urandom());
            // Phase 0 of each four runs with no idling at all
            tx_gaps_on   = (phase % 4 == 1) || (phase % 4 == 2);
            rx_stalls_on = (phase % 4 == 1) || (phase % 4 == 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_step(pick_index());
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Register values after reset
        line_cfg            = '0;
        line_cfg.brush_half = BRUSH_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_lines();
        test_backpressure();
        test_sender_pause();
        test_random_lines();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
